/* rtl/lifegen_pkg.sv */
package lifegen_pkg;

  // Field widths of the stream items
  localparam int ROW_IDX_W = 5;
  localparam int ROW_W     = 64;
  localparam int TDATA_W   = 72;

  // Build-time defaults for the grid size
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 32;
  localparam int ROWS_LIMIT      = 32;

  // Configuration register widths, reset values and port geometry
  localparam int COLS_REG_W = 7;
  localparam int ROWS_REG_W = 6;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd64;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd32;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int MIN_SIZE = 3;

  // Register indexes, selected by address bit 2
  localparam logic REG_ACTIVE_COLUMNS = 1'b0;
  localparam logic REG_ACTIVE_ROWS    = 1'b1;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // B3/S23 neighbor counts
  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef struct packed {
    logic [COLS_REG_W-1:0] active_columns;
    logic [ROWS_REG_W-1:0] active_rows;
  } cfg_t;

endpackage

/* rtl/lifegen_regs.sv */
module lifegen_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lifegen_pkg::CFG_AW-1:0] paddr,
  input  logic [lifegen_pkg::CFG_DW-1:0] pwdata,
  output logic [lifegen_pkg::CFG_DW-1:0] prdata,
  output logic                           pready,
  output lifegen_pkg::cfg_t              cfg
);
  import lifegen_pkg::*;

  logic wr_req;

  assign pready = 1'b1;
  assign wr_req = psel && penable && pwrite;

  // Write the selected register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_columns <= COLS_RESET;
      cfg.active_rows    <= ROWS_RESET;
    end else if (wr_req) begin
      unique case (paddr[2])
        REG_ACTIVE_COLUMNS: cfg.active_columns <= pwdata[COLS_REG_W-1:0];
        REG_ACTIVE_ROWS:    cfg.active_rows    <= pwdata[ROWS_REG_W-1:0];
        default:            cfg.active_rows    <= cfg.active_rows;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE_COLUMNS: prdata = CFG_DW'(cfg.active_columns);
      REG_ACTIVE_ROWS:    prdata = CFG_DW'(cfg.active_rows);
      default:            prdata = '0;
    endcase
  end

endmodule

/* rtl/lifegen_grid.sv */
module lifegen_grid #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_v;

  // Store rows; no reset on the array itself
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written rows; reset makes every row read as dead
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Register the read row and its valid bit
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
      rd_v <= valid[rd_addr];
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

/* rtl/lifegen_row_unit.sv */
module lifegen_row_unit #(
  parameter int MAX_COLUMNS = 64,
  parameter int CW          = $clog2(MAX_COLUMNS + 1)
) (
  input  logic [MAX_COLUMNS-1:0] up,
  input  logic [MAX_COLUMNS-1:0] mid,
  input  logic [MAX_COLUMNS-1:0] down,
  input  logic [CW-1:0]          cols,
  output logic [MAX_COLUMNS-1:0] next_row
);
  import lifegen_pkg::*;

  localparam int CIW = $clog2(MAX_COLUMNS);

  logic [CIW-1:0] last_col;
  logic           up_wrap;
  logic           mid_wrap;
  logic           down_wrap;

  // Pick the bits that column zero sees on its left
  assign last_col  = CIW'(cols - CW'(1));
  assign up_wrap   = up[last_col];
  assign mid_wrap  = mid[last_col];
  assign down_wrap = down[last_col];

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
    logic       is_last;
    logic       up_l, mid_l, down_l;
    logic       up_r, mid_r, down_r;
    logic [3:0] n;

    assign is_last = (CW'(c) == cols - CW'(1));

    // Left neighbors wrap from the last active column
    if (c == 0) begin : g_left_wrap
      assign up_l   = up_wrap;
      assign mid_l  = mid_wrap;
      assign down_l = down_wrap;
    end else begin : g_left
      assign up_l   = up[c-1];
      assign mid_l  = mid[c-1];
      assign down_l = down[c-1];
    end

    // Right neighbors wrap to column zero
    if (c == MAX_COLUMNS - 1) begin : g_right_wrap
      assign up_r   = up[0];
      assign mid_r  = mid[0];
      assign down_r = down[0];
    end else begin : g_right
      assign up_r   = is_last ? up[0]   : up[c+1];
      assign mid_r  = is_last ? mid[0]  : mid[c+1];
      assign down_r = is_last ? down[0] : down[c+1];
    end

    // Count the eight neighbors and apply B3/S23
    assign n = 4'(up_l) + 4'(up[c]) + 4'(up_r) + 4'(mid_l) + 4'(mid_r)
             + 4'(down_l) + 4'(down[c]) + 4'(down_r);

    assign next_row[c] = (CW'(c) < cols)
                      && ((n == BIRTH_COUNT) || (mid[c] && (n == SURVIVE_LOW)));
  end

endmodule

/* rtl/life_automaton_generation.sv */
// A load request is written as it is accepted; the block is ready again on the next cycle.
// A step request reads rows R-1, 0 .. R-1 in turn: the single grid read port
// delivers one row per cycle while the output is not stalled, three reads fill the
// row window, and the row unit then writes one new row and one result per cycle, under the same condition.
// A result held by the master side stalls the step sequence until taken.
// Reset (rst, synchronous) sets 64 columns and 32 rows and marks all rows dead.
module life_automaton_generation #(
  parameter int MAX_COLUMNS = lifegen_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = lifegen_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lifegen_pkg::CFG_AW-1:0]  paddr,
  input  logic [lifegen_pkg::CFG_DW-1:0]  pwdata,
  output logic [lifegen_pkg::CFG_DW-1:0]  prdata,
  output logic                            pready,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lifegen_pkg::TDATA_W-1:0] s_tdata,   // row_index[4:0], row_cells[68:5]
  input  logic                            s_tuser,   // func
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lifegen_pkg::TDATA_W-1:0] m_tdata,   // out_row_index[4:0], out_row_cells[68:5]
  output logic                            m_tlast    // last_row
);
  import lifegen_pkg::*;

  localparam int DEPTH = (MAX_ROWS < ROWS_LIMIT) ? MAX_ROWS : ROWS_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int LEAD  = 4;
  localparam int SW    = $clog2(DEPTH + LEAD);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_STEP = 1'b1;

  cfg_t                   cfg;
  logic                   state;
  logic [SW-1:0]          seq;
  logic [CW-1:0]          cols_eff;
  logic [RW-1:0]          rows_eff;
  logic                   en;
  logic                   in_req;
  logic [ROW_IDX_W-1:0]   in_index;
  logic [ROW_W-1:0]       in_cells;
  logic                   emit;
  logic                   done;
  logic [SW-1:0]          out_pos;
  logic [MAX_COLUMNS-1:0] up;
  logic [MAX_COLUMNS-1:0] mid;
  logic [MAX_COLUMNS-1:0] down;
  logic [MAX_COLUMNS-1:0] row0;
  logic [MAX_COLUMNS-1:0] rd_data;
  logic [MAX_COLUMNS-1:0] new_row;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [MAX_COLUMNS-1:0] wr_data;
  logic [ROW_IDX_W-1:0]   out_index;
  logic [ROW_W-1:0]       out_cells;

  lifegen_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Saturate the grid size into its legal range
  always_comb begin
    if (cfg.active_columns < COLS_REG_W'(MIN_SIZE)) begin
      cols_eff = CW'(MIN_SIZE);
    end else if (cfg.active_columns > COLS_REG_W'(MAX_COLUMNS)) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = CW'(cfg.active_columns);
    end
    if (cfg.active_rows < ROWS_REG_W'(MIN_SIZE)) begin
      rows_eff = RW'(MIN_SIZE);
    end else if (cfg.active_rows > ROWS_REG_W'(DEPTH)) begin
      rows_eff = RW'(DEPTH);
    end else begin
      rows_eff = RW'(cfg.active_rows);
    end
  end

  assign in_index = s_tdata[ROW_IDX_W-1:0];
  assign in_cells = s_tdata[ROW_IDX_W+ROW_W-1:ROW_IDX_W];
  assign s_tready = (state == ST_IDLE);
  assign in_req   = s_tvalid && s_tready;

  // Advance the step only when the output slot can take a row
  assign en      = (state == ST_STEP) && (!m_tvalid || m_tready);
  assign emit    = en && (seq >= SW'(LEAD));
  assign done    = en && (seq == SW'(rows_eff) + SW'(LEAD - 1));
  assign out_pos = seq - SW'(LEAD);

  // Read rows R-1, 0, 1, .. R-1 in turn
  assign rd_en   = en && (seq <= SW'(rows_eff));
  assign rd_addr = (seq == '0) ? AW'(rows_eff - RW'(1)) : AW'(seq - SW'(1));

  // Share the write port between loads and the step write-back
  always_comb begin
    if (state == ST_STEP) begin
      wr_en   = emit;
      wr_addr = AW'(out_pos);
      wr_data = new_row;
    end else begin
      wr_en   = in_req && (s_tuser == FUNC_LOAD)
             && (ROW_IDX_W'(in_index) < ROW_IDX_W'(DEPTH - 1) + ROW_IDX_W'(1) ||
                 DEPTH >= ROWS_LIMIT);
      wr_addr = AW'(in_index);
      wr_data = in_cells[MAX_COLUMNS-1:0];
    end
  end

  lifegen_grid #(
    .DEPTH (DEPTH),
    .WIDTH (MAX_COLUMNS),
    .AW    (AW)
  ) u_grid (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lifegen_row_unit #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .CW          (CW)
  ) u_row_unit (
    .up       (up),
    .mid      (mid),
    .down     (down),
    .cols     (cols_eff),
    .next_row (new_row)
  );

  // Sequence the step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seq   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_req && (s_tuser == FUNC_STEP)) begin
            state <= ST_STEP;
            seq   <= '0;
          end
        end
        ST_STEP: begin
          if (done) begin
            state <= ST_IDLE;
          end else if (en) begin
            seq <= seq + SW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Slide the three-row window; feed the saved old row 0 at the end
  always_ff @(posedge clk) begin
    if (en) begin
      up   <= mid;
      mid  <= down;
      down <= (seq == SW'(rows_eff) + SW'(LEAD - 2)) ? row0 : rd_data;
      if (seq == SW'(2)) begin
        row0 <= rd_data;
      end
    end
  end

  // Hold the result until the master side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_STEP) begin
      if (en) begin
        m_tvalid <= emit;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= ROW_IDX_W'(out_pos);
      out_cells <= ROW_W'(new_row);
      m_tlast   <= done;
    end
  end

  assign m_tdata = {{(TDATA_W - ROW_W - ROW_IDX_W){1'b0}}, out_cells, out_index};

endmodule

/* tb/life_generation_checker.sv */
module life_generation_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lifegen_pkg::CFG_AW-1:0]  paddr,
  input  logic [lifegen_pkg::CFG_DW-1:0]  pwdata,
  input  logic                            pready,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [lifegen_pkg::TDATA_W-1:0] s_tdata,   // row_index[4:0], row_cells[68:5]
  input  logic                            s_tuser,   // func
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [lifegen_pkg::TDATA_W-1:0] m_tdata,   // out_row_index[4:0], out_row_cells[68:5]
  input  logic                            m_tlast,   // last_row
  output int                              fail_count,
  output int                              pending_count
);
  import lifegen_pkg::*;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     cells;
    logic                 last_row;
  } gen_row_t;

  // Shadow of the block: cell grid and size registers
  logic [ROW_W-1:0]      cell_rows [MAX_ROWS_DEF];
  logic [COLS_REG_W-1:0] cols_reg;
  logic [ROWS_REG_W-1:0] rows_reg;

  // New-generation rows still owed by the block, oldest first
  gen_row_t gen_rows_due [$];
  int       mismatches = 0;

  always @(posedge clk) begin : track
    logic [ROW_W-1:0] next_gen [MAX_ROWS_DEF];
    logic [ROW_W-1:0] up, mid, dn, nrow;
    int cols, rows, lc, rc, n;
    gen_row_t want;

    if (rst) begin
      for (int r = 0; r < MAX_ROWS_DEF; r++) cell_rows[r] = '0;
      cols_reg = COLS_RESET;
      rows_reg = ROWS_RESET;
      gen_rows_due.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ACTIVE_COLUMNS) cols_reg = pwdata[COLS_REG_W-1:0];
        else rows_reg = pwdata[ROWS_REG_W-1:0];
      end

      // Apply an accepted request: store a row, or advance one generation
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_LOAD) begin
          cell_rows[s_tdata[ROW_IDX_W-1:0]] = s_tdata[ROW_IDX_W +: ROW_W];
        end else begin
          cols = cols_reg;
          if (cols < MIN_SIZE) cols = MIN_SIZE;
          if (cols > MAX_COLUMNS_DEF) cols = MAX_COLUMNS_DEF;
          rows = rows_reg;
          if (rows < MIN_SIZE) rows = MIN_SIZE;
          if (rows > MAX_ROWS_DEF) rows = MAX_ROWS_DEF;
          if (rows > ROWS_LIMIT) rows = ROWS_LIMIT;

          // Compute all new rows from the old grid before writing any back
          for (int r = 0; r < rows; r++) begin
            up   = cell_rows[(r + rows - 1) % rows];
            mid  = cell_rows[r];
            dn   = cell_rows[(r + 1) % rows];
            nrow = '0;
            for (int c = 0; c < cols; c++) begin
              lc = (c + cols - 1) % cols;
              rc = (c + 1) % cols;
              n  = up[lc] + up[c] + up[rc] + mid[lc] + mid[rc] + dn[lc] + dn[c] + dn[rc];
              if ((mid[c] && (n == SURVIVE_LOW || n == BIRTH_COUNT)) ||
                  (!mid[c] && n == BIRTH_COUNT))
                nrow[c] = 1'b1;
            end
            next_gen[r] = nrow;
          end

          for (int r = 0; r < rows; r++) begin
            cell_rows[r] = next_gen[r];
            want = '{row_index: ROW_IDX_W'(r), cells: next_gen[r],
                     last_row: (r == rows - 1)};
            gen_rows_due.insert(gen_rows_due.size(), want);
          end
        end
      end

      // Compare each emitted row with the oldest one owed
      if (m_tvalid && m_tready) begin
        if (gen_rows_due.size() == 0) begin
          $error("unexpected row: out_row_index %0d, out_row_cells %h",
                 m_tdata[ROW_IDX_W-1:0], m_tdata[ROW_IDX_W +: ROW_W]);
          mismatches++;
        end else begin
          want = gen_rows_due.pop_front();
          if (m_tdata[ROW_IDX_W-1:0] !== want.row_index) begin
            $error("out_row_index: expected %0d, actual %0d",
                   want.row_index, m_tdata[ROW_IDX_W-1:0]);
            mismatches++;
          end
          if (m_tdata[ROW_IDX_W +: ROW_W] !== want.cells) begin
            $error("out_row_cells: expected %h, actual %h",
                   want.cells, m_tdata[ROW_IDX_W +: ROW_W]);
            mismatches++;
          end
          if (m_tlast !== want.last_row) begin
            $error("last_row: expected %0d, actual %0d", want.last_row, m_tlast);
            mismatches++;
          end
        end
      end
    end

    fail_count    <= mismatches;
    pending_count <= gen_rows_due.size();
  end

endmodule

/* tb/tb_life_automaton_generation.sv */
module tb_life_automaton_generation;
  import lifegen_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT        = 160;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 130;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;
  logic               s_tvalid, s_tready;
  logic [TDATA_W-1:0] s_tdata;   // row_index[4:0], row_cells[68:5]
  logic               s_tuser;   // func
  logic               m_tvalid, m_tready;
  logic [TDATA_W-1:0] m_tdata;   // out_row_index[4:0], out_row_cells[68:5]
  logic               m_tlast;   // last_row

  int fail_count;
  int pending_count;
  int src_gap_max;
  int sink_gap_max;
  int random_items;
  int idle_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  life_automaton_generation u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  life_generation_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Mix dense, sparse and even cell patterns
  function automatic logic [ROW_W-1:0] random_cells();
    logic [ROW_W-1:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return a & b;
      1:       return a | b;
      2:       return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic func, input logic [ROW_IDX_W-1:0] idx,
                              input logic [ROW_W-1:0] cells);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {{(TDATA_W - ROW_W - ROW_IDX_W){1'b0}}, cells, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, wait for every owed row, then let the block go quiet
  task automatic settle_block();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Resize the grid while idle; upper data bits carry junk the register drops
  task automatic apply_size(input int cols, input int rows);
    settle_block();
    write_register({REG_ACTIVE_COLUMNS, 2'b00},
                   ($urandom & (32'hFFFF_FFFF << COLS_REG_W)) | cols);
    write_register({REG_ACTIVE_ROWS, 2'b00},
                   ($urandom & (32'hFFFF_FFFF << ROWS_REG_W)) | rows);
  endtask

  initial begin : stimulus
    int cols_w, rows_w, rows_eff, seqs;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tuser  <= FUNC_LOAD;
    s_tdata  <= '0;
    src_gap_max  = 4;
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Full grid after reset: full row, corner cells, blinker, empty row
    send_request(FUNC_LOAD, 5'd0, {ROW_W{1'b1}});
    send_request(FUNC_LOAD, 5'd31, 64'h8000_0000_0000_0001);
    send_request(FUNC_LOAD, 5'd16, 64'h0000_0000_0000_0007);
    send_request(FUNC_LOAD, 5'd5, '0);
    send_request(FUNC_STEP, 5'd0, '0);
    send_request(FUNC_STEP, 5'd31, {ROW_W{1'b1}});

    // Smallest torus, bits beyond the active columns, a row beyond the active rows
    apply_size(MIN_SIZE, MIN_SIZE);
    send_request(FUNC_LOAD, 5'd0, 64'hFFFF_FFFF_FFFF_FFF2);
    send_request(FUNC_LOAD, 5'd1, 64'h0000_0000_0000_0005);
    send_request(FUNC_LOAD, 5'd2, 64'h0000_0000_0000_0002);
    send_request(FUNC_LOAD, 5'd20, 64'hDEAD_BEEF_0123_4567);
    send_request(FUNC_STEP, 5'd0, '0);
    send_request(FUNC_STEP, 5'd0, '0);

    // Out-of-range sizes saturate at both ends
    apply_size(2, 63);
    send_request(FUNC_STEP, 5'd0, '0);
    apply_size(127, 2);
    send_request(FUNC_STEP, 5'd0, '0);
    send_request(FUNC_LOAD, 5'd2, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(FUNC_STEP, 5'd0, '0);
    apply_size(0, 0);
    send_request(FUNC_STEP, 5'd0, '0);

    // Largest grid with a glider
    apply_size(MAX_COLUMNS_DEF, MAX_ROWS_DEF);
    send_request(FUNC_LOAD, 5'd31, {ROW_W{1'b1}});
    send_request(FUNC_LOAD, 5'd10, 64'h0000_0000_0000_0002);
    send_request(FUNC_LOAD, 5'd11, 64'h0000_0000_0000_0004);
    send_request(FUNC_LOAD, 5'd12, 64'h0000_0000_0000_0007);
    send_request(FUNC_STEP, 5'd0, '0);
    send_request(FUNC_STEP, 5'd0, '0);

    // Random phases: mostly full grid loads followed by steps, some stray requests
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       cols_w = MIN_SIZE;
        1:       cols_w = MAX_COLUMNS_DEF;
        2:       cols_w = $urandom_range(0, 127);
        default: cols_w = $urandom_range(MIN_SIZE, 16);
      endcase
      case ($urandom_range(0, 5))
        0:       rows_w = MIN_SIZE;
        1:       rows_w = MAX_ROWS_DEF;
        2:       rows_w = $urandom_range(0, 63);
        default: rows_w = $urandom_range(MIN_SIZE, 8);
      endcase
      apply_size(cols_w, rows_w);
      rows_eff = (rows_w < MIN_SIZE) ? MIN_SIZE :
                 ((rows_w > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_w);
      seqs = $urandom_range(1, 3);
      repeat (seqs) begin
        src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(2, 6)) begin
            send_request(1'($urandom_range(0, 1)), ROW_IDX_W'($urandom_range(0, 31)),
                         random_cells());
            random_items++;
          end
        end else begin
          for (int r = 0; r < rows_eff; r++) begin
            send_request(FUNC_LOAD, ROW_IDX_W'(r), random_cells());
            random_items++;
          end
          if ($urandom_range(0, 3) == 0) begin
            send_request(FUNC_LOAD, ROW_IDX_W'($urandom_range(0, 31)), random_cells());
            random_items++;
          end
          repeat ($urandom_range(1, 4)) begin
            send_request(FUNC_STEP, ROW_IDX_W'($urandom_range(0, 31)), random_cells());
            random_items++;
          end
        end
      end
    end

    settle_block();
    if (fail_count == 0 && pending_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Take rows with random stalls; once, hold off long enough to back up the input
  initial begin : result_sink
    int  stall, taken;
    bit  held;
    m_tready <= 1'b0;
    taken        = 0;
    held         = 1'b0;
    sink_gap_max = 4;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && taken >= HOLD_AT && s_tvalid) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      if (taken % 20 == 0) sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/lifegen_pkg.sv
rtl/lifegen_regs.sv
rtl/lifegen_grid.sv
rtl/lifegen_row_unit.sv
rtl/life_automaton_generation.sv
tb/life_generation_checker.sv
tb/tb_life_automaton_generation.sv
